// ===== hw/rtl/s2r_pkg.sv =====
// ----------------------------------------------------------------------------
// s2r_pkg
// Shared constants and types for the scalar to RGB colormap pipeline.
// ----------------------------------------------------------------------------
package s2r_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 24;
  localparam int unsigned QFRAC_DEF       = 16;

  // map modes
  localparam logic [2:0] MODE_DIVERGING = 3'd0;
  localparam logic [2:0] MODE_HOT       = 3'd1;
  localparam logic [2:0] MODE_COLD      = 3'd2;
  localparam logic [2:0] MODE_JET       = 3'd3;
  localparam logic [2:0] MODE_CYCLIC    = 3'd4;
  localparam logic [2:0] MODE_GRAY     = 3'd5;
  localparam logic [2:0] MODE_BLUE      = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_MODE  = 2'd0;
  localparam logic [1:0] CFG_RANGE_MIN = 2'd1;
  localparam logic [1:0] CFG_RANGE_MAX = 2'd2;

  localparam logic [7:0] COLOR_FULL = 8'd255;
  localparam logic [7:0] JET_BASE   = 8'd144;
  localparam logic [7:0] JET_SPAN   = 8'd111;
  localparam logic [7:0] POS_BASE   = 8'd192;
  localparam logic [7:0] POS_SPAN   = 8'd63;

  // source of one colour channel, picked before the fraction is known
  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_FULL,
    SRC_UP,
    SRC_DOWN,
    SRC_INV_UP,
    SRC_INV_DOWN,
    SRC_JET,
    SRC_POS,
    SRC_HALF
  } src_e;

  typedef struct packed {
    src_e red;
    src_e green;
    src_e blue;
  } chan_sel_t;

endpackage

// ===== hw/rtl/scalar_to_rgb_colormap_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap_unit
// Maps a signed fixed-point sample to an RGB pixel through a configured map.
// ----------------------------------------------------------------------------
//  channel  signals                           moves
//  in       in_valid_i / in_ready_o           sample_value_i request
//  out      out_valid_o / out_ready_i         red_o, green_o, blue_o
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i   register write, no wait
//
//  One request per cycle while the output is not held, through the bit-per-stage
//  remainder pipeline and the bit-per-stage fraction divider.
//  Reset clears all valid bits and loads mode 0, minimum 0, maximum 255.
//  A held output stalls every stage at once; in_ready_o follows it.
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap_unit import s2r_pkg::*; #(
  parameter int unsigned VALUE_WIDTH            = VALUE_WIDTH_DEF,
  parameter int unsigned QUOTIENT_FRACTION_BITS = QFRAC_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] sample_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned V = VALUE_WIDTH;
  localparam int unsigned Q = QUOTIENT_FRACTION_BITS;

  logic [2:0]   map_mode_q;
  logic [V-1:0] range_min_q, range_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q  <= MODE_DIVERGING;
      range_min_q <= '0;
      range_max_q <= V'(COLOR_FULL);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_MODE:  map_mode_q  <= cfg_data_i[2:0];
        CFG_RANGE_MIN: range_min_q <= cfg_data_i;
        CFG_RANGE_MAX: range_max_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds an untaken result
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic         m_vld;
  logic [2:0]   m_mode;
  logic [V-1:0] m_smp, m_min, m_max, m_rem;
  logic [V:0]   m_diff, m_span;

  s2r_mod #(.VALUE_WIDTH(V)) u_mod (
    .clk_i, .rst_ni,
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .sample_i (sample_value_i),
    .mode_i   (map_mode_q),
    .min_i    (range_min_q),
    .max_i    (range_max_q),
    .valid_o  (m_vld),
    .mode_o   (m_mode),
    .sample_o (m_smp),
    .min_o    (m_min),
    .max_o    (m_max),
    .diff_o   (m_diff),
    .span_o   (m_span),
    .rem_o    (m_rem)
  );

  logic         b_vld;
  chan_sel_t    b_sel;
  logic [V-1:0] b_num, b_den;

  s2r_band #(.VALUE_WIDTH(V)) u_band (
    .clk_i, .rst_ni,
    .adv_i    (adv),
    .valid_i  (m_vld),
    .mode_i   (m_mode),
    .sample_i (m_smp),
    .min_i    (m_min),
    .max_i    (m_max),
    .diff_i   (m_diff),
    .span_i   (m_span),
    .rem_i    (m_rem),
    .valid_o  (b_vld),
    .sel_o    (b_sel),
    .num_o    (b_num),
    .den_o    (b_den)
  );

  logic         f_vld;
  chan_sel_t    f_sel;
  logic [Q-1:0] f_frac;

  s2r_frac #(.VALUE_WIDTH(V), .QUOTIENT_FRACTION_BITS(Q)) u_frac (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (b_vld),
    .sel_i   (b_sel),
    .num_i   (b_num),
    .den_i   (b_den),
    .valid_o (f_vld),
    .sel_o   (f_sel),
    .frac_o  (f_frac)
  );

  s2r_color #(.QUOTIENT_FRACTION_BITS(Q)) u_color (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (f_vld),
    .sel_i   (f_sel),
    .frac_i  (f_frac),
    .valid_o (out_valid_o),
    .red_o,
    .green_o,
    .blue_o
  );

  // a fraction is only ever taken from a nonzero divisor
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld && !(b_sel.red == SRC_ZERO || b_sel.red == SRC_FULL) |-> b_den != '0)
    else $error("band stage issued a fraction with zero divisor");

  // a valid fraction below one half drives no half-scale term
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld && adv && (f_sel.blue == SRC_HALF) && !f_frac[Q-1] |=>
      (u_color.p_half_q == 8'd0))
    else $error("half-scale term set for a fraction below one half");

  // a result leaves the output register only through a handshake
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output result dropped without handshake");

endmodule

// ===== hw/rtl/s2r_mod.sv =====
// ----------------------------------------------------------------------------
// s2r_mod
// Input stage and bit-serial pipelined remainder of the offset by the range.
// ----------------------------------------------------------------------------
module s2r_mod import s2r_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic [VALUE_WIDTH-1:0] sample_i,
  input  logic [2:0]             mode_i,
  input  logic [VALUE_WIDTH-1:0] min_i,
  input  logic [VALUE_WIDTH-1:0] max_i,
  output logic                   valid_o,
  output logic [2:0]             mode_o,
  output logic [VALUE_WIDTH-1:0] sample_o,
  output logic [VALUE_WIDTH-1:0] min_o,
  output logic [VALUE_WIDTH-1:0] max_o,
  output logic [VALUE_WIDTH:0]   diff_o,
  output logic [VALUE_WIDTH:0]   span_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int unsigned V = VALUE_WIDTH;
  localparam int unsigned N = VALUE_WIDTH + 1;

  logic           vld_s  [0:N];
  logic [2:0]     mode_s [0:N];
  logic [V-1:0]   smp_s  [0:N];
  logic [V-1:0]   min_s  [0:N];
  logic [V-1:0]   max_s  [0:N];
  logic [V:0]     diff_s [0:N];
  logic [V:0]     span_s [0:N];
  logic [V:0]     dabs_s [0:N];
  logic [V-1:0]   rem_s  [0:N];

  logic [V:0] diff_d, span_d, dabs_d;

  assign diff_d = {sample_i[V-1], sample_i} - {min_i[V-1], min_i};
  assign span_d = {max_i[V-1], max_i} - {min_i[V-1], min_i};
  assign dabs_d = diff_d[V] ? ('0 - diff_d) : diff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s[0] <= 1'b0;
    end else if (adv_i) begin
      vld_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode_s[0] <= mode_i;
      smp_s[0]  <= sample_i;
      min_s[0]  <= min_i;
      max_s[0]  <= max_i;
      diff_s[0] <= diff_d;
      span_s[0] <= span_d;
      dabs_s[0] <= dabs_d;
    end
  end

  assign rem_s[0] = '0;

  // one dividend bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [V:0]   r2;
    logic [V:0]   dv;
    logic [V:0]   sub;
    logic [V-1:0] rem_d;

    assign r2    = {rem_s[k], dabs_s[k][V-k]};
    assign dv    = {1'b0, span_s[k][V-1:0]};
    assign sub   = r2 - dv;
    assign rem_d = (r2 >= dv) ? sub[V-1:0] : r2[V-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        mode_s[k+1] <= mode_s[k];
        smp_s[k+1]  <= smp_s[k];
        min_s[k+1]  <= min_s[k];
        max_s[k+1]  <= max_s[k];
        diff_s[k+1] <= diff_s[k];
        span_s[k+1] <= span_s[k];
        dabs_s[k+1] <= dabs_s[k];
        rem_s[k+1]  <= rem_d;
      end
    end
  end

  assign valid_o  = vld_s[N];
  assign mode_o   = mode_s[N];
  assign sample_o = smp_s[N];
  assign min_o    = min_s[N];
  assign max_o    = max_s[N];
  assign diff_o   = diff_s[N];
  assign span_o   = span_s[N];
  assign rem_o    = rem_s[N];

endmodule

// ===== hw/rtl/s2r_band.sv =====
// ----------------------------------------------------------------------------
// s2r_band
// Picks the band, the channel sources and the divider operands per map.
// ----------------------------------------------------------------------------
module s2r_band import s2r_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic [2:0]             mode_i,
  input  logic [VALUE_WIDTH-1:0] sample_i,
  input  logic [VALUE_WIDTH-1:0] min_i,
  input  logic [VALUE_WIDTH-1:0] max_i,
  input  logic [VALUE_WIDTH:0]   diff_i,
  input  logic [VALUE_WIDTH:0]   span_i,
  input  logic [VALUE_WIDTH-1:0] rem_i,
  output logic                   valid_o,
  output chan_sel_t              sel_o,
  output logic [VALUE_WIDTH-1:0] num_o,
  output logic [VALUE_WIDTH-1:0] den_o
);

  localparam int unsigned V  = VALUE_WIDTH;
  localparam int unsigned TW = VALUE_WIDTH + 3;

  // stage A: wrapped offset and band thresholds
  logic [V-1:0]  x_d, w_d;
  logic [TW-1:0] r1_d;

  logic          a_vld_q;
  logic [2:0]    a_mode_q;
  logic [V-1:0]  a_smp_q, a_min_q, a_max_q, a_x_q;
  logic [V:0]    a_diff_q, a_span_q;
  logic [TW-1:0] a_t3_q, a_t4_q, a_r1_q, a_r2_q, a_r3_q;

  assign w_d  = (diff_i[V] && (rem_i != '0)) ? (span_i[V-1:0] - rem_i) : rem_i;
  assign x_d  = (mode_i == MODE_CYCLIC) ? w_d : diff_i[V-1:0];
  assign r1_d = TW'(span_i[V-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_mode_q <= mode_i;
      a_smp_q  <= sample_i;
      a_min_q  <= min_i;
      a_max_q  <= max_i;
      a_diff_q <= diff_i;
      a_span_q <= span_i;
      a_x_q    <= x_d;
      a_t3_q   <= TW'(x_d) + (TW'(x_d) << 1);
      a_t4_q   <= TW'(x_d) << 2;
      a_r1_q   <= r1_d;
      a_r2_q   <= {r1_d[TW-2:0], 1'b0};
      a_r3_q   <= r1_d + {r1_d[TW-2:0], 1'b0};
    end
  end

  // stage B: classification
  logic          empty, dneg, dge, vpos, vge_max, vzero;
  logic [TW-1:0] t3_m1, t3_m2, t4_m1, t4_m2, t4_m3;
  logic [V-1:0]  neg_min;
  chan_sel_t     sel_d;
  logic [V-1:0]  num_d, den_d;

  assign empty   = !($signed(a_span_q) > $signed({(V+1){1'b0}}));
  assign dneg    = a_diff_q[V];
  assign dge     = $signed(a_diff_q) >= $signed(a_span_q);
  assign vpos    = $signed(a_smp_q) > $signed({V{1'b0}});
  assign vge_max = $signed(a_smp_q) >= $signed(a_max_q);
  assign vzero   = (a_smp_q == '0);
  assign t3_m1   = a_t3_q - a_r1_q;
  assign t3_m2   = a_t3_q - a_r2_q;
  assign t4_m1   = a_t4_q - a_r1_q;
  assign t4_m2   = a_t4_q - a_r2_q;
  assign t4_m3   = a_t4_q - a_r3_q;
  assign neg_min = '0 - a_min_q;

  always_comb begin
    sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
    num_d = '0;
    den_d = a_span_q[V-1:0];
    case (a_mode_q)
      MODE_HOT, MODE_COLD: begin
        if (dneg) begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
        end else if (dge) begin
          sel_d = '{red: SRC_FULL, green: SRC_FULL, blue: SRC_FULL};
        end else if (a_t3_q < a_r1_q) begin
          sel_d = '{red: SRC_UP, green: SRC_ZERO, blue: SRC_ZERO};
          num_d = a_t3_q[V-1:0];
        end else if (a_t3_q < a_r2_q) begin
          sel_d = '{red: SRC_FULL, green: SRC_UP, blue: SRC_ZERO};
          num_d = t3_m1[V-1:0];
        end else begin
          sel_d = '{red: SRC_FULL, green: SRC_FULL, blue: SRC_UP};
          num_d = t3_m2[V-1:0];
        end
        // cold is hot with red and blue swapped
        if (a_mode_q == MODE_COLD) begin
          sel_d = '{red: sel_d.blue, green: sel_d.green, blue: sel_d.red};
        end
      end
      MODE_JET: begin
        if (dneg) begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
        end else if (dge) begin
          sel_d = '{red: SRC_FULL, green: SRC_ZERO, blue: SRC_ZERO};
        end else if (a_t4_q < a_r1_q) begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_JET};
          num_d = a_t4_q[V-1:0];
        end else if (a_t4_q < a_r2_q) begin
          sel_d = '{red: SRC_ZERO, green: SRC_UP, blue: SRC_FULL};
          num_d = t4_m1[V-1:0];
        end else if (a_t4_q < a_r3_q) begin
          sel_d = '{red: SRC_UP, green: SRC_FULL, blue: SRC_INV_UP};
          num_d = t4_m2[V-1:0];
        end else begin
          sel_d = '{red: SRC_FULL, green: SRC_DOWN, blue: SRC_ZERO};
          num_d = t4_m3[V-1:0];
        end
      end
      MODE_CYCLIC: begin
        if (a_t3_q < a_r1_q) begin
          sel_d = '{red: SRC_DOWN, green: SRC_ZERO, blue: SRC_INV_DOWN};
          num_d = a_t3_q[V-1:0];
        end else if (a_t3_q < a_r2_q) begin
          sel_d = '{red: SRC_ZERO, green: SRC_UP, blue: SRC_INV_UP};
          num_d = t3_m1[V-1:0];
        end else begin
          sel_d = '{red: SRC_UP, green: SRC_INV_UP, blue: SRC_ZERO};
          num_d = t3_m2[V-1:0];
        end
      end
      MODE_GRAY: begin
        num_d = a_x_q;
        if (dneg) begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
        end else if (dge) begin
          sel_d = '{red: SRC_FULL, green: SRC_FULL, blue: SRC_FULL};
        end else begin
          sel_d = '{red: SRC_UP, green: SRC_UP, blue: SRC_UP};
        end
      end
      MODE_BLUE: begin
        num_d = a_x_q;
        if (dneg) begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
        end else if (dge) begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_FULL};
        end else begin
          sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_UP};
        end
      end
      default: begin
        // diverging, also taken by the unused mode code
        if (vpos) begin
          num_d = a_smp_q;
          den_d = a_max_q;
          if (vge_max) begin
            sel_d = '{red: SRC_FULL, green: SRC_FULL, blue: SRC_FULL};
          end else begin
            sel_d = '{red: SRC_POS, green: SRC_UP, blue: SRC_HALF};
          end
        end else begin
          num_d = a_diff_q[V-1:0];
          den_d = neg_min;
          if (dneg) begin
            sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
          end else if (vzero) begin
            sel_d = '{red: SRC_ZERO, green: SRC_FULL, blue: SRC_FULL};
          end else begin
            sel_d = '{red: SRC_ZERO, green: SRC_UP, blue: SRC_HALF};
          end
        end
      end
    endcase
    if (empty) begin
      sel_d = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
    end
    // keep the divisor nonzero where no fraction is used
    if (den_d == '0) begin
      den_d = V'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sel_o <= sel_d;
      num_o <= num_d;
      den_o <= den_d;
    end
  end

endmodule

// ===== hw/rtl/s2r_frac.sv =====
// ----------------------------------------------------------------------------
// s2r_frac
// Pipelined restoring divider: one fraction bit of num/den per stage.
// ----------------------------------------------------------------------------
module s2r_frac import s2r_pkg::*; #(
  parameter int unsigned VALUE_WIDTH            = VALUE_WIDTH_DEF,
  parameter int unsigned QUOTIENT_FRACTION_BITS = QFRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  chan_sel_t                         sel_i,
  input  logic [VALUE_WIDTH-1:0]            num_i,
  input  logic [VALUE_WIDTH-1:0]            den_i,
  output logic                              valid_o,
  output chan_sel_t                         sel_o,
  output logic [QUOTIENT_FRACTION_BITS-1:0] frac_o
);

  localparam int unsigned V = VALUE_WIDTH;
  localparam int unsigned Q = QUOTIENT_FRACTION_BITS;

  logic         vld_s [0:Q];
  chan_sel_t    sel_s [0:Q];
  logic [V-1:0] rem_s [0:Q];
  logic [V-1:0] den_s [0:Q];
  logic [Q-1:0] quo_s [0:Q];

  assign vld_s[0] = valid_i;
  assign sel_s[0] = sel_i;
  assign rem_s[0] = num_i;
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [V:0] r2;
    logic [V:0] dv;
    logic [V:0] sub;
    logic       ge;

    assign r2  = {rem_s[k], 1'b0};
    assign dv  = {1'b0, den_s[k]};
    assign sub = r2 - dv;
    assign ge  = (r2 >= dv);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sel_s[k+1] <= sel_s[k];
        den_s[k+1] <= den_s[k];
        rem_s[k+1] <= ge ? sub[V-1:0] : r2[V-1:0];
        quo_s[k+1] <= {quo_s[k][Q-2:0], ge};
      end
    end
  end

  assign valid_o = vld_s[Q];
  assign sel_o   = sel_s[Q];
  assign frac_o  = quo_s[Q];

endmodule

// ===== hw/rtl/s2r_color.sv =====
// ----------------------------------------------------------------------------
// s2r_color
// Scales the fraction into channel terms, then selects and registers RGB.
// ----------------------------------------------------------------------------
module s2r_color import s2r_pkg::*; #(
  parameter int unsigned QUOTIENT_FRACTION_BITS = QFRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  chan_sel_t                         sel_i,
  input  logic [QUOTIENT_FRACTION_BITS-1:0] frac_i,
  output logic                              valid_o,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o
);

  localparam int unsigned Q   = QUOTIENT_FRACTION_BITS;
  localparam int unsigned PW  = QUOTIENT_FRACTION_BITS + 8;
  localparam int unsigned PW1 = QUOTIENT_FRACTION_BITS + 9;

  logic [PW-1:0]  m_up, m_jet, m_pos, m_half;
  logic [PW1-1:0] m_down;
  logic [Q:0]     one_minus;
  logic [Q-1:0]   twice_m1;
  logic           above_half;

  assign one_minus  = {1'b1, {Q{1'b0}}} - {1'b0, frac_i};
  assign twice_m1   = {frac_i[Q-2:0], 1'b0};
  assign above_half = frac_i[Q-1] && (frac_i[Q-2:0] != '0);
  assign m_up       = PW'(frac_i) * PW'(COLOR_FULL);
  assign m_jet      = PW'(frac_i) * PW'(JET_SPAN);
  assign m_pos      = PW'(frac_i) * PW'(POS_SPAN);
  assign m_half     = PW'(twice_m1) * PW'(COLOR_FULL);
  assign m_down     = PW1'(one_minus) * PW1'(COLOR_FULL);

  logic       p_vld_q;
  chan_sel_t  p_sel_q;
  logic [7:0] p_up_q, p_down_q, p_jet_q, p_pos_q, p_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv_i) begin
      p_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_sel_q  <= sel_i;
      p_up_q   <= m_up[Q+7:Q];
      p_down_q <= m_down[Q+7:Q];
      p_jet_q  <= m_jet[Q+7:Q];
      p_pos_q  <= m_pos[Q+7:Q];
      p_half_q <= above_half ? m_half[Q+7:Q] : 8'd0;
    end
  end

  function automatic logic [7:0] pick(src_e s, logic [7:0] up, logic [7:0] dn,
                                      logic [7:0] jet, logic [7:0] pos,
                                      logic [7:0] half);
    logic [7:0] r;
    case (s)
      SRC_ZERO:     r = 8'd0;
      SRC_FULL:     r = COLOR_FULL;
      SRC_UP:       r = up;
      SRC_DOWN:     r = dn;
      SRC_INV_UP:   r = COLOR_FULL - up;
      SRC_INV_DOWN: r = COLOR_FULL - dn;
      SRC_JET:      r = JET_BASE + jet;
      SRC_POS:      r = POS_BASE + pos;
      SRC_HALF:     r = half;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      red_o   <= pick(p_sel_q.red, p_up_q, p_down_q, p_jet_q, p_pos_q, p_half_q);
      green_o <= pick(p_sel_q.green, p_up_q, p_down_q, p_jet_q, p_pos_q, p_half_q);
      blue_o  <= pick(p_sel_q.blue, p_up_q, p_down_q, p_jet_q, p_pos_q, p_half_q);
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams signed samples through the colormap unit under a series of map
// modes and ranges, predicts each pixel in integer arithmetic and compares
// every returned pixel, in order, with the predicted one.
// ----------------------------------------------------------------------------
module tb_top import s2r_pkg::*; ();

  localparam int VW       = 24;
  localparam int QF       = 16;
  localparam int LAT      = VW + QF + 6;
  localparam int WD_MAX   = 20000;
  localparam int HOLD_LEN = LAT * 3;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  logic          clk_i, rst_ni;
  logic          in_valid_i, out_ready_i;
  logic          in_ready_o, out_valid_o;
  logic [VW-1:0] sample_value_i;
  logic [7:0]    red_o, green_o, blue_o;
  logic          cfg_we_i;
  logic [1:0]    cfg_idx_i;
  logic [VW-1:0] cfg_data_i;

  scalar_to_rgb_colormap_unit DUT (.*);

  logic [2:0]    cur_mode;
  logic [VW-1:0] cur_min, cur_max;

  logic [VW-1:0] sample_q[$];
  pixel_t        pixel_q[$];
  int            n_err, n_pix, n_sent, idle_cnt, hold_cnt;
  bit            src_idle_ok, snk_idle_ok, snk_hold;
  bit            src_pause;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sx(logic [VW-1:0] raw);
    return longint'(signed'(raw));
  endfunction

  function automatic longint fr(longint num, longint den);
    return (num <<< QF) / den;
  endfunction

  function automatic logic [7:0] up8(longint k, longint f);
    return 8'((k * f) >>> QF);
  endfunction

  function automatic logic [7:0] dn8(longint k, longint f);
    return 8'((k * ((longint'(1) <<< QF) - f)) >>> QF);
  endfunction

  function automatic logic [7:0] half8(longint f);
    longint one;
    one = longint'(1) <<< QF;
    return (2 * f > one) ? up8(255, 2 * f - one) : 8'd0;
  endfunction

  function automatic pixel_t map_pixel(logic [VW-1:0] raw);
    longint v, mn, mx, rr, d, w, f;
    logic [7:0] c;
    logic [2:0] m;
    pixel_t p;
    v  = sx(raw);
    mn = sx(cur_min);
    mx = sx(cur_max);
    rr = mx - mn;
    d  = v - mn;
    m  = (cur_mode == 3'd7) ? MODE_DIVERGING : cur_mode;
    p  = '0;
    if (rr <= 0) return p;
    case (m)
      MODE_HOT: begin
        if (d < 0) p = '0;
        else if (3 * d < rr) p = '{up8(255, fr(3 * d, rr)), 8'd0, 8'd0};
        else if (3 * d < 2 * rr) p = '{8'd255, up8(255, fr(3 * d - rr, rr)), 8'd0};
        else if (d < rr) p = '{8'd255, 8'd255, up8(255, fr(3 * d - 2 * rr, rr))};
        else p = '{8'd255, 8'd255, 8'd255};
      end
      MODE_COLD: begin
        if (d < 0) p = '0;
        else if (3 * d < rr) p = '{8'd0, 8'd0, up8(255, fr(3 * d, rr))};
        else if (3 * d < 2 * rr) p = '{8'd0, up8(255, fr(3 * d - rr, rr)), 8'd255};
        else if (d < rr) p = '{up8(255, fr(3 * d - 2 * rr, rr)), 8'd255, 8'd255};
        else p = '{8'd255, 8'd255, 8'd255};
      end
      MODE_JET: begin
        if (d < 0) p = '0;
        else if (4 * d < rr) p = '{8'd0, 8'd0, 8'(144 + up8(111, fr(4 * d, rr)))};
        else if (4 * d < 2 * rr) p = '{8'd0, up8(255, fr(4 * d - rr, rr)), 8'd255};
        else if (4 * d < 3 * rr) begin
          c = up8(255, fr(4 * d - 2 * rr, rr));
          p = '{c, 8'd255, 8'd255 - c};
        end else if (d < rr) p = '{8'd255, dn8(255, fr(4 * d - 3 * rr, rr)), 8'd0};
        else p = '{8'd255, 8'd0, 8'd0};
      end
      MODE_CYCLIC: begin
        w = d % rr;
        if (w < 0) w += rr;
        if (3 * w < rr) begin
          c = dn8(255, fr(3 * w, rr));
          p = '{c, 8'd0, 8'd255 - c};
        end else if (3 * w < 2 * rr) begin
          c = up8(255, fr(3 * w - rr, rr));
          p = '{8'd0, c, 8'd255 - c};
        end else begin
          c = up8(255, fr(3 * w - 2 * rr, rr));
          p = '{c, 8'd255 - c, 8'd0};
        end
      end
      MODE_GRAY: begin
        if (d < 0) p = '0;
        else if (d < rr) begin
          c = up8(255, fr(d, rr));
          p = '{c, c, c};
        end else p = '{8'd255, 8'd255, 8'd255};
      end
      MODE_BLUE: begin
        if (d < 0) p = '0;
        else if (d < rr) p = '{8'd0, 8'd0, up8(255, fr(d, rr))};
        else p = '{8'd0, 8'd0, 8'd255};
      end
      default: begin
        if (v > 0) begin
          if (v >= mx) p = '{8'd255, 8'd255, 8'd255};
          else begin
            f = fr(v, mx);
            p = '{8'(192 + up8(63, f)), up8(255, f), half8(f)};
          end
        end else if (v < mn) p = '0;
        else if (v == 0) p = '{8'd0, 8'd255, 8'd255};
        else begin
          f = fr(v - mn, -mn);
          p = '{8'd0, up8(255, f), half8(f)};
        end
      end
    endcase
    return p;
  endfunction

  // driver: offer the next request; hold it until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      sample_value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pixel_q.push_back(map_pixel(sample_value_i));
        n_sent <= n_sent + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() > 0 && !src_pause &&
            !(src_idle_ok && $urandom_range(99) < 27)) begin
          in_valid_i     <= 1'b1;
          sample_value_i <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each returned pixel against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_pix <= n_pix + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel %h %h %h", $time, red_o, green_o, blue_o);
          n_err <= n_err + 1;
        end else begin
          pixel_t e;
          e = pixel_q.pop_front();
          if (e != {red_o, green_o, blue_o}) begin
            $display("%0t: pixel expected %h %h %h actual %h %h %h", $time,
                     e.r, e.g, e.b, red_o, green_o, blue_o);
            n_err <= n_err + 1;
          end
        end
      end
      // count the long hold here, one cycle per edge
      if (snk_hold && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
      out_ready_i <= !(snk_hold && hold_cnt < HOLD_LEN) &&
                     !(snk_idle_ok && $urandom_range(99) < 27);
    end
  end

  // watchdog: count cycles with no accepted request on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WD_MAX) begin
      $display("scalar_to_rgb_colormap_unit: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (sample_q.size() > 0 || in_valid_i || pixel_q.size() > 0) @(negedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [VW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAP_MODE) cur_mode = val[2:0];
    else if (idx == CFG_RANGE_MIN) cur_min = val;
    else if (idx == CFG_RANGE_MAX) cur_max = val;
  endtask

  function automatic logic [VW-1:0] pick_sample();
    longint mn, mx, rr;
    mn = sx(cur_min);
    mx = sx(cur_max);
    rr = mx - mn;
    case ($urandom_range(9))
      0:       return VW'($urandom);
      1:       return {1'b1, {(VW - 1){1'b0}}};
      2:       return {1'b0, {(VW - 1){1'b1}}};
      3:       return VW'(mn + (rr > 0 ? (rr * $urandom_range(4)) / 4 : 0));
      default: return (rr > 0 && rr < 32'h7fffffff) ?
                 VW'(mn - rr / 8 + longint'($urandom_range(32'(rr + rr / 4)))) :
                 VW'($urandom);
    endcase
  endfunction

  task automatic run_phase(logic [2:0] m, logic [VW-1:0] lo, logic [VW-1:0] hi, int n);
    write_reg(CFG_MAP_MODE, {{(VW - 3){1'b0}}, m});
    write_reg(CFG_RANGE_MIN, lo);
    write_reg(CFG_RANGE_MAX, hi);
    // spurious index is ignored by the block
    if ($urandom_range(3) == 0) write_reg(2'd3, VW'($urandom));
    for (int i = 0; i < n; i++) sample_q.push_back(pick_sample());
    drain();
  endtask

  logic [VW-1:0] lo, hi;

  initial begin
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    cur_mode    = MODE_DIVERGING;
    cur_min     = '0;
    cur_max     = VW'(255);
    n_err       = 0;
    n_pix       = 0;
    n_sent      = 0;
    idle_cnt    = 0;
    hold_cnt    = 0;
    src_idle_ok = 1'b0;
    snk_idle_ok = 1'b0;
    snk_hold    = 1'b0;
    src_pause   = 1'b0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, extremes of the sample, then each mode's band edges
    foreach (lo[i]) begin
      sample_q.push_back(VW'(1) << i);
    end
    sample_q.push_back('0);
    sample_q.push_back('1);
    sample_q.push_back(VW'(255));
    sample_q.push_back(VW'(256));
    sample_q.push_back({1'b1, {(VW - 1){1'b0}}});
    drain();
    for (int m = 0; m < 8; m++) begin
      run_phase(3'(m), VW'(-300), VW'(600), 10);
      for (int k = -1; k <= 5; k++) sample_q.push_back(VW'(-300 + 225 * k));
      drain();
    end
    // empty range and a single-step range
    run_phase(MODE_HOT, VW'(100), VW'(100), 6);
    run_phase(MODE_JET, VW'(100), VW'(-100), 6);
    run_phase(MODE_GRAY, VW'(5), VW'(6), 6);
    // full-scale range
    run_phase(MODE_CYCLIC, {1'b1, {(VW - 1){1'b0}}}, {1'b0, {(VW - 1){1'b1}}}, 12);
    run_phase(MODE_DIVERGING, {1'b1, {(VW - 1){1'b0}}}, {1'b0, {(VW - 1){1'b1}}}, 12);

    // stall the output long enough to fill the pipeline and block the input
    snk_hold = 1'b1;
    for (int i = 0; i < 80; i++) sample_q.push_back(pick_sample());
    wait (hold_cnt >= HOLD_LEN);
    snk_hold = 1'b0;
    drain();

    // random phases with idling on both sides
    src_idle_ok = 1'b1;
    snk_idle_ok = 1'b1;
    for (int ph = 0; ph < 24; ph++) begin
      lo = VW'($urandom);
      hi = VW'($urandom);
      if ($urandom_range(3) != 0) begin
        lo = VW'(longint'($urandom_range(4000)) - 2000);
        hi = VW'(sx(lo) + 1 + $urandom_range(3000));
      end
      if (ph == 12) begin
        src_idle_ok = 1'b0;
        snk_idle_ok = 1'b0;
      end
      if (ph == 18) begin
        src_idle_ok = 1'b1;
        snk_idle_ok = 1'b1;
      end
      run_phase(3'($urandom_range(7)), lo, hi, 24);
      // hold the source until every outstanding pixel is back, then resume
      sample_q.push_back(pick_sample());
      sample_q.push_back(pick_sample());
      src_pause = 1'b1;
      @(negedge clk_i);
      while (in_valid_i || pixel_q.size() > 0) @(negedge clk_i);
      src_pause = 1'b0;
      drain();
    end
    drain();

    $display("covered all eight mode codes, empty, tiny and full-scale ranges;");
    $display("%0d samples sent, %0d pixels checked, %0d errors", n_sent, n_pix, n_err);
    if (n_err == 0) $display("scalar_to_rgb_colormap_unit: match");
    else $display("scalar_to_rgb_colormap_unit: mismatch");
    $finish;
  end
endmodule
